// ===== src/bloom_filter_murmur_insert_query_macros.svh =====
// Assertion helpers, clocked on clk with synchronous active-low reset rst_n.
`ifndef BLOOM_FILTER_MURMUR_INSERT_QUERY_MACROS_SVH
`define BLOOM_FILTER_MURMUR_INSERT_QUERY_MACROS_SVH

// same-cycle implication
`define BFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bfm_pkg.sv =====
package bfm_pkg;

  localparam int unsigned MAX_FILTER_BYTES_DEF = 1024;
  localparam logic [4:0]  MAX_PROBES   = 5'd30;
  localparam logic [31:0] HASH_SEED    = 32'hbc9f1d34;
  localparam logic [31:0] MIX_C1       = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2       = 32'h1b873593;
  localparam logic [31:0] MIX_ADD      = 32'he6546b64;
  localparam logic [31:0] FMIX_C1      = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2      = 32'hc2b2ae35;

  localparam logic [10:0] FB_RESET     = 11'd128;
  localparam logic [4:0]  NP_RESET     = 5'd6;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] REG_FILTER_BYTES = 2'd0;
  localparam logic [1:0] REG_NUM_PROBES   = 2'd1;

  typedef struct packed {
    logic       absorb;
    logic       finish;
    logic       restart;
    logic [7:0] data;
  } hash_cmd_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hash;
  } hash_sts_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    rotl15 = {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    rotl13 = {x[18:0], x[31:19]};
  endfunction

  function automatic logic [31:0] rotr17(input logic [31:0] x);
    rotr17 = {x[16:0], x[31:17]};
  endfunction

endpackage

// ===== src/bfm_hash.sv =====
module bfm_hash
  import bfm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hash_cmd_t cmd,
  output hash_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K1   = 3'd1;
  localparam logic [2:0] S_K2   = 3'd2;
  localparam logic [2:0] S_MIX  = 3'd3;
  localparam logic [2:0] S_F3   = 3'd4;
  localparam logic [2:0] S_F4   = 3'd5;
  localparam logic [2:0] S_F5   = 3'd6;

  logic [2:0]  st_r;
  logic [31:0] h_r, w_r, len_r, t_r, hash_r;
  logic [1:0]  fill_r;
  logic        fin_r, done_r;
  logic [31:0] w_new, f3_x, f4_x, mix_x;

  always_comb begin
    case (fill_r)
      2'd0:    w_new = w_r | {24'd0, cmd.data};
      2'd1:    w_new = w_r | {16'd0, cmd.data, 8'd0};
      2'd2:    w_new = w_r | {8'd0, cmd.data, 16'd0};
      default: w_new = w_r | {cmd.data, 24'd0};
    endcase
    // tail block folds in only when present; t_r holds it after S_K2
    f3_x  = h_r ^ len_r ^ ((fill_r != 2'd0) ? t_r : 32'd0);
    f3_x  = f3_x ^ (f3_x >> 16);
    f4_x  = t_r ^ (t_r >> 13);
    mix_x = rotl13(h_r ^ t_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      h_r    <= HASH_SEED;
      w_r    <= '0;
      fill_r <= '0;
      len_r  <= '0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (cmd.restart) begin
            h_r    <= HASH_SEED;
            w_r    <= '0;
            fill_r <= '0;
            len_r  <= '0;
          end else if (cmd.absorb) begin
            w_r   <= w_new;
            len_r <= len_r + 32'd1;
            fin_r <= 1'b0;
            if (fill_r == 2'd3) begin
              st_r <= S_K1;
            end else begin
              fill_r <= fill_r + 2'd1;
              done_r <= 1'b1;
            end
          end else if (cmd.finish) begin
            fin_r <= 1'b1;
            st_r  <= (fill_r != 2'd0) ? S_K1 : S_F3;
          end
        end
        S_K1: begin
          t_r  <= w_r * MIX_C1;
          st_r <= S_K2;
        end
        S_K2: begin
          t_r  <= rotl15(t_r) * MIX_C2;
          st_r <= fin_r ? S_F3 : S_MIX;
        end
        S_MIX: begin
          h_r    <= (mix_x << 2) + mix_x + MIX_ADD;
          w_r    <= '0;
          fill_r <= '0;
          done_r <= 1'b1;
          st_r   <= S_IDLE;
        end
        S_F3: begin
          t_r  <= f3_x * FMIX_C1;
          st_r <= S_F4;
        end
        S_F4: begin
          t_r  <= f4_x * FMIX_C2;
          st_r <= S_F5;
        end
        S_F5: begin
          hash_r <= t_r ^ (t_r >> 16);
          h_r    <= HASH_SEED;
          w_r    <= '0;
          fill_r <= '0;
          len_r  <= '0;
          done_r <= 1'b1;
          st_r   <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign sts.done = done_r;
  assign sts.hash = hash_r;

endmodule

// ===== src/bfm_mod.sv =====
module bfm_mod
  import bfm_pkg::*;
#(
  parameter int unsigned BW = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [BW-1:0] divisor,
  output logic          done,
  output logic [BW-1:0] rem
);

  // restoring division, one quotient bit per cycle, remainder only
  logic [31:0]   dvd_r;
  logic [BW-1:0] rem_r;
  logic [4:0]    cnt_r;
  logic          run_r, done_r;
  logic [BW:0]   trial;

  assign trial = {rem_r, dvd_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r <= dividend;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (trial >= {1'b0, divisor}) rem_r <= BW'(trial - {1'b0, divisor});
        else                          rem_r <= trial[BW-1:0];
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== src/bfm_store.sv =====
module bfm_store
  import bfm_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_FILTER_BYTES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr_start,
  output logic          clr_busy,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0]    mem [DEPTH];
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;

  // zeroing sweep, one byte a cycle; runs from reset and on each clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_start) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) clr_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r)      mem[clr_addr_r] <= 8'd0;
    else if (wr_en) mem[wr_addr]    <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign clr_busy = clr_r;

endmodule

// ===== src/bloom_filter_murmur_insert_query.sv =====
// Bloom filter, MurmurHash3 x86_32 keyed, double hashing. Keys stream in at most
// one byte per item; busy gates start. A byte that completes a 4-byte block
// also passes through the block scramble and mix (the hash unit does one
// 32-bit multiply a cycle). The key_last item then finishes the hash and runs
// each probe in turn: a bit-serial modulo, a store read and, for inserts, a
// read-modify-write. Queries end at the first clear bit. A query's answer
// appears on out_may_match for one cycle with out_valid high; it cannot be
// held off, so capture it on that cycle. After reset and after each clear
// item the store is zeroed, all MAX_FILTER_BYTES bytes, with busy high;
// configuration may be written at any time the block is idle.
module bloom_filter_murmur_insert_query
  import bfm_pkg::*;
#(
  parameter int unsigned MAX_FILTER_BYTES = MAX_FILTER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_key_byte,
  input  logic        in_byte_valid,
  input  logic        in_key_last,
  output logic        out_valid,
  output logic        out_may_match,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

`include "bloom_filter_murmur_insert_query_macros.svh"

  localparam int unsigned AW = $clog2(MAX_FILTER_BYTES);
  localparam int unsigned BW = $clog2(MAX_FILTER_BYTES * 8 + 1);
  localparam int unsigned NW = $clog2(MAX_FILTER_BYTES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HASH_B = 3'd1;
  localparam logic [2:0] ST_HASH_F = 3'd2;
  localparam logic [2:0] ST_MOD    = 3'd3;
  localparam logic [2:0] ST_CHK    = 3'd4;

  logic [2:0]    st_r;
  logic [10:0]   fb_r;
  logic [4:0]    np_r;
  logic          accept;
  logic          is_query_r, last_r;
  logic [BW-1:0] bits_r;
  logic [4:0]    probes_r, cnt_r;
  logic [31:0]   h_r, delta_r;
  logic [2:0]    bsel_r;
  logic [AW-1:0] addr_r;
  logic          out_valid_r, out_match_r;

  hash_cmd_t     hcmd;
  hash_sts_t     hsts;
  logic          mod_start, mod_done;
  logic [BW-1:0] mod_rem;
  logic          clr_busy, rd_en, wr_en;
  logic [7:0]    rd_data, wr_data, mask;
  logic [NW-1:0] nbytes;
  logic [4:0]    probes_cl;

  assign accept    = start && !busy;
  assign busy      = (st_r != ST_IDLE) || clr_busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= FB_RESET;
      np_r <= NP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FILTER_BYTES: fb_r <= cfg_data;
        REG_NUM_PROBES:   np_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // size and probe count clamped to their legal ranges
  always_comb begin
    if ({21'd0, fb_r} < 32'd8)
      nbytes = NW'(8);
    else if ({21'd0, fb_r} > 32'(MAX_FILTER_BYTES))
      nbytes = NW'(MAX_FILTER_BYTES);
    else
      nbytes = NW'(fb_r);
    probes_cl = (np_r > MAX_PROBES) ? MAX_PROBES : np_r;
  end

  always_comb begin
    hcmd.absorb  = accept && (in_command == CMD_INSERT || in_command == CMD_QUERY)
                   && in_byte_valid;
    hcmd.finish  = (accept && (in_command == CMD_INSERT || in_command == CMD_QUERY)
                    && !in_byte_valid && in_key_last)
                   || (st_r == ST_HASH_B && hsts.done && last_r);
    hcmd.restart = accept && (in_command == CMD_CLEAR);
    hcmd.data    = in_key_byte;
  end

  assign mask    = 8'd1 << bsel_r;
  assign wr_data = rd_data | mask;
  assign wr_en   = (st_r == ST_CHK) && !is_query_r;
  assign rd_en   = (st_r == ST_MOD) && mod_done;
  assign mod_start = ((st_r == ST_HASH_F) && hsts.done && (probes_r != 5'd0))
                     || ((st_r == ST_CHK) && (cnt_r + 5'd1 != probes_r)
                         && (!is_query_r || ((rd_data & mask) != 8'd0)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (accept && (in_command == CMD_INSERT || in_command == CMD_QUERY)) begin
            is_query_r <= (in_command == CMD_QUERY);
            last_r     <= in_key_last;
            bits_r     <= BW'({nbytes, 3'b000});
            probes_r   <= probes_cl;
            if (in_byte_valid)    st_r <= ST_HASH_B;
            else if (in_key_last) st_r <= ST_HASH_F;
          end
        end
        ST_HASH_B: begin
          if (hsts.done) st_r <= last_r ? ST_HASH_F : ST_IDLE;
        end
        ST_HASH_F: begin
          if (hsts.done) begin
            h_r     <= hsts.hash + rotr17(hsts.hash);
            delta_r <= rotr17(hsts.hash);
            cnt_r   <= '0;
            if (probes_r == 5'd0) begin
              out_valid_r <= is_query_r;
              out_match_r <= 1'b1;
              st_r        <= ST_IDLE;
            end else begin
              st_r <= ST_MOD;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            addr_r <= mod_rem[AW+2:3];
            bsel_r <= mod_rem[2:0];
            st_r   <= ST_CHK;
          end
        end
        ST_CHK: begin
          if (is_query_r && ((rd_data & mask) == 8'd0)) begin
            out_valid_r <= 1'b1;
            out_match_r <= 1'b0;
            st_r        <= ST_IDLE;
          end else if (cnt_r + 5'd1 == probes_r) begin
            out_valid_r <= is_query_r;
            out_match_r <= 1'b1;
            st_r        <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 5'd1;
            h_r   <= h_r + delta_r;
            st_r  <= ST_MOD;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // dividend: first probe uses the fresh hash, later ones the stepped h_r
  logic [31:0] mod_dvd;
  assign mod_dvd = (st_r == ST_HASH_F) ? hsts.hash : h_r;

  bfm_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hcmd),
    .sts   (hsts)
  );

  bfm_mod #(.BW(BW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (bits_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  bfm_store #(.DEPTH(MAX_FILTER_BYTES), .AW(AW)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr_start (hcmd.restart),
    .clr_busy  (clr_busy),
    .rd_en     (rd_en),
    .rd_addr   (mod_rem[AW+2:3]),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (addr_r),
    .wr_data   (wr_data)
  );

  assign out_valid     = out_valid_r;
  assign out_may_match = out_match_r;

  `BFM_ASSERT_NOW(a_no_wr_in_clear, wr_en, !clr_busy, "store write during clear sweep")
  `BFM_ASSERT_NEXT(a_single_result, out_valid_r, !out_valid_r, "two results back to back")
  `BFM_ASSERT_NOW(a_mod_idle_start, mod_start, !(st_r == ST_IDLE), "probe started while idle")

endmodule

// ===== tb/tb_bloom_filter_murmur_insert_query.sv =====
`timescale 1ns / 1ps

module tb_bloom_filter_murmur_insert_query;
  import bfm_pkg::*;

  // Worst key end: hash finish plus 30 probes; a clear sweeps all 1024 store bytes.
  localparam int SETTLE_CYCLES = 1300;
  localparam int CYCLE_LIMIT   = 3000000;
  localparam int STORE_BYTES   = 1024;
  localparam int PHASE_ITEMS   = 92;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_NONE;
  logic [7:0]  in_key_byte = 8'd0;
  logic        in_byte_valid = 1'b0;
  logic        in_key_last = 1'b0;
  logic        out_valid;
  logic        out_may_match;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_FILTER_BYTES;
  logic [10:0] cfg_data = 11'd0;

  bloom_filter_murmur_insert_query dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_key_byte(in_key_byte),
    .in_byte_valid(in_byte_valid), .in_key_last(in_key_last),
    .out_valid(out_valid), .out_may_match(out_may_match),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // --- mirror of the filter: registers, running hash, bit store ---
  logic [10:0] mir_fbytes;
  logic [4:0]  mir_probes;
  logic [31:0] mir_hash, mir_word, mir_len;
  logic [1:0]  mir_fill;
  logic [7:0]  mir_store [STORE_BYTES];

  logic        answers [$];   // may_match answers still to come
  int          errors = 0;
  int          cycles = 0;
  bit          gaps_on = 1'b1;
  int          sent = 0;

  function automatic logic [31:0] rol(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] blk_scramble(input logic [31:0] k);
    return rol(k * MIX_C1, 15) * MIX_C2;
  endfunction

  function automatic void key_reset();
    mir_hash = HASH_SEED;
    mir_word = '0;
    mir_fill = '0;
    mir_len  = '0;
  endfunction

  function automatic void store_wipe();
    foreach (mir_store[i]) mir_store[i] = 8'h00;
  endfunction

  // Work out what one accepted item does; has_ans set when a query answer is due.
  function automatic void filter_item(input logic [1:0] c, input logic [7:0] b,
                                      input logic v, input logic l,
                                      output bit has_ans, output logic ans);
    logic [31:0] h, step, nbits, bp;
    int unsigned nb, np;
    has_ans = 1'b0;
    ans = 1'b1;
    if (c == CMD_CLEAR) begin
      store_wipe();
      key_reset();
      return;
    end
    if (c == CMD_NONE) return;
    if (v) begin
      mir_word |= 32'(b) << (8 * mir_fill);
      mir_len += 1;
      if (mir_fill == 2'd3) begin
        mir_hash = rol(mir_hash ^ blk_scramble(mir_word), 13) * 5 + MIX_ADD;
        mir_word = '0;
      end
      mir_fill += 1;
    end
    if (!l) return;
    nb = (mir_fbytes < 8) ? 8 : (mir_fbytes > STORE_BYTES) ? STORE_BYTES : mir_fbytes;
    np = (mir_probes > MAX_PROBES) ? MAX_PROBES : mir_probes;
    nbits = nb * 8;
    h = mir_hash;
    if (mir_fill != 0) h ^= blk_scramble(mir_word);
    h ^= mir_len;
    h ^= h >> 16;
    h *= FMIX_C1;
    h ^= h >> 13;
    h *= FMIX_C2;
    h ^= h >> 16;
    key_reset();
    step = {h[16:0], h[31:17]};
    for (int j = 0; j < np; j++) begin
      bp = h % nbits;
      if (c == CMD_INSERT) mir_store[bp >> 3][bp[2:0]] = 1'b1;
      else if (!mir_store[bp >> 3][bp[2:0]]) begin
        ans = 1'b0;
        break;
      end
      h += step;
    end
    has_ans = (c == CMD_QUERY);
  endfunction

  task automatic report(input string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Offer one item at the falling edge; start stays high after acceptance so
  // back-to-back items keep it asserted.
  task automatic put_item(input logic [1:0] c, input logic [7:0] b, input logic v,
                          input logic l, input bit known = 1'b0, input logic kval = 1'b0);
    bit   has;
    logic ans;
    if (gaps_on && $urandom_range(99) < 7) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1'b1;
    in_command = c;
    in_key_byte = b;
    in_byte_valid = v;
    in_key_last = l;
    do @(posedge clk); while (busy);
    filter_item(c, b, v, l, has, ans);
    if (has) begin
      if (known && ans !== kval) report($sformatf("table answer %0b, mirror %0b", kval, ans));
      answers = {answers, (known ? kval : ans)};
    end
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (answers.size() != 0) @(negedge clk);
  endtask

  // Register writes only with the block idle: drain, then let any insert or
  // clear still in flight finish.
  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FILTER_BYTES) mir_fbytes = val;
    else if (idx == REG_NUM_PROBES) mir_probes = val[4:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Small key dictionary so queries often hit keys already inserted.
  int          dict_len [16];
  logic [7:0]  dict_key [16][8];

  task automatic send_key(input logic [1:0] last_cmd, input int k);
    logic [1:0] c;
    for (int i = 0; i < dict_len[k]; i++) begin
      c = ($urandom_range(99) < 15) ? (($urandom_range(1)) ? CMD_INSERT : CMD_QUERY)
                                    : last_cmd;
      if ($urandom_range(99) < 8) put_item(c, 8'($urandom), 1'b0, 1'b0);
      if (i == dict_len[k] - 1 && $urandom_range(99) < 70)
        put_item(last_cmd, dict_key[k][i], 1'b1, 1'b1);
      else begin
        put_item(c, dict_key[k][i], 1'b1, 1'b0);
        if (i == dict_len[k] - 1) put_item(last_cmd, 8'($urandom), 1'b0, 1'b1);
      end
    end
    if (dict_len[k] == 0) put_item(last_cmd, 8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic random_phase(input int n);
    int goal;
    int r;
    goal = sent + n;
    while (sent < goal) begin
      r = $urandom_range(99);
      if (r < 4) put_item(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      else if (r < 6) put_item(CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
      else if (r < 20) begin
        // fresh random key, full byte range
        dict_len[0] = $urandom_range(0, 8);
        foreach (dict_key[0][i]) dict_key[0][i] = 8'($urandom);
        send_key(($urandom_range(1)) ? CMD_INSERT : CMD_QUERY, 0);
      end else send_key(($urandom_range(99) < 45) ? CMD_INSERT : CMD_QUERY,
                        $urandom_range(1, 15));
    end
  endtask

  // Directed rows: command, byte, byte_valid, key_last, answer known, answer.
  typedef struct {
    logic [1:0] c;
    logic [7:0] b;
    logic       v, l;
    bit         known;
    logic       kval;
  } row_t;

  row_t rows [$] = '{
    '{CMD_QUERY,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0},   // empty key, empty store
    '{CMD_QUERY,  8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_QUERY,  8'hff, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_NONE,   8'hff, 1'b1, 1'b1, 1'b0, 1'b0},   // unused command, ignored
    '{CMD_INSERT, 8'hff, 1'b1, 1'b1, 1'b0, 1'b0},
    '{CMD_QUERY,  8'hff, 1'b1, 1'b1, 1'b1, 1'b1},   // just inserted
    '{CMD_INSERT, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0},   // empty key insert
    '{CMD_QUERY,  8'h5a, 1'b0, 1'b1, 1'b1, 1'b1},
    // five-byte key, mixed commands and an absent byte, insert decides
    '{CMD_QUERY,  8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_INSERT, 8'h62, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY,  8'h33, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY,  8'h63, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY,  8'h64, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_INSERT, 8'h65, 1'b1, 1'b1, 1'b0, 1'b0},
    '{CMD_INSERT, 8'h61, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_INSERT, 8'h62, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_INSERT, 8'h63, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY,  8'h64, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY,  8'h65, 1'b1, 1'b1, 1'b1, 1'b1},
    // clear abandons the key in progress and wipes the store
    '{CMD_INSERT, 8'h12, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_CLEAR,  8'hff, 1'b1, 1'b1, 1'b0, 1'b0},
    '{CMD_QUERY,  8'hff, 1'b1, 1'b1, 1'b1, 1'b0},
    '{CMD_QUERY,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0}
  };

  // Configurations: extremes and out-of-range values on both registers.
  logic [10:0] ph_fb [8] = '{11'd8, 11'd1024, 11'd0, 11'd2047, 11'd7, 11'd1025, 11'd200, 11'd16};
  logic [10:0] ph_np [8] = '{11'd1, 11'd30, 11'd0, 11'd31, 11'd5, 11'd3, 11'd6, 11'd2};

  // Answers are strobed for one cycle only; capture on every rising edge.
  always @(posedge clk) begin : answer_check
    logic e;
    if (rst_n && out_valid) begin
      if (answers.size() == 0) report("answer with none outstanding");
      else begin
        e = answers.pop_front();
        if (out_may_match !== e)
          report($sformatf("may_match %0b, wanted %0b", out_may_match, e));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    mir_fbytes = FB_RESET;
    mir_probes = NP_RESET;
    key_reset();
    store_wipe();
    for (int k = 0; k < 16; k++) begin
      dict_len[k] = $urandom_range(0, 7);
      foreach (dict_key[k][i]) dict_key[k][i] = 8'($urandom_range(0, 3));
    end
    dict_len[1] = 8;
    foreach (dict_key[1][i]) dict_key[1][i] = 8'hff;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) put_item(rows[i].c, rows[i].b, rows[i].v, rows[i].l,
                               rows[i].known, rows[i].kval);

    for (int p = 0; p < 8; p++) begin
      write_reg(REG_FILTER_BYTES, ph_fb[p]);
      write_reg(REG_NUM_PROBES, ph_np[p]);
      gaps_on = (p != 2);               // one long stretch with no idling
      if (p == 4) begin
        random_phase(PHASE_ITEMS / 2);
        drain();                         // hold off until all answers are in
        random_phase(PHASE_ITEMS / 2);
      end else random_phase(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/bfm_pkg.sv
src/bfm_hash.sv
src/bfm_mod.sv
src/bfm_store.sv
src/bloom_filter_murmur_insert_query.sv
tb/tb_bloom_filter_murmur_insert_query.sv
